### hw/rtl/sidc_pkg.sv
// Shared widths, payload types and constants of the strided descriptor coalescer.
`timescale 1ns / 1ps

package sidc_pkg;

    localparam int BASE_W   = 48;
    localparam int BSIZE_W  = 32;
    localparam int GAP_W    = 32;
    localparam int REQ_W    = 16;
    localparam int SIZE_W   = 48;
    localparam int REP_W    = 32;
    localparam int TOTAL_W  = 17;
    localparam int SPAN_W   = BSIZE_W + 1;
    localparam int EXT_W    = SIZE_W + 1;
    localparam int END_W    = BASE_W + 2;
    localparam int SAT_W    = BASE_W + REP_W + 2;
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [BSIZE_W-1:0] block_size;
        logic [GAP_W-1:0]   gap;
        logic [REQ_W-1:0]   repeat_req;
        logic               last_item;
    } item_t;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic [GAP_W-1:0]   gap;
        logic [REP_W-1:0]   repeat_cnt;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } result_t;

    typedef struct packed {
        logic first;
        logic second;
    } emit_t;

endpackage

### hw/rtl/sidc_merge.sv
// Pending descriptor state with the merge decision, flattening and end tracking.
`timescale 1ns / 1ps

module sidc_merge
    import sidc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output emit_t   emit,
    output result_t res_a,
    output result_t res_b
);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;
    localparam logic [REP_W-1:0]   REP_MAX   = '1;

    logic               pv_reg, pv_next;
    logic [BASE_W-1:0]  pbase_reg, pbase_next;
    logic [SIZE_W-1:0]  psize_reg, psize_next;
    logic [GAP_W-1:0]   pgap_reg, pgap_next;
    logic [REP_W-1:0]   prep_reg, prep_next;
    logic [BASE_W-1:0]  pend_reg, pend_next;
    logic               pbig_reg, pbig_next;
    logic [TOTAL_W-1:0] cnt_reg, cnt_next;

    logic               gap_zero;
    logic [SIZE_W-1:0]  flat;
    logic [SIZE_W-1:0]  nsize;
    logic [REP_W-1:0]   nrep;
    logic [SPAN_W-1:0]  nspan;
    logic [EXT_W-1:0]   ext_prod;
    logic [EXT_W-1:0]   ext;
    logic [END_W-1:0]   load_end;
    logic               merge_ok;
    logic [EXT_W-1:0]   ssum;
    logic [SIZE_W-1:0]  size_sat;
    logic [EXT_W-1:0]   zend;
    logic [REP_W:0]     rsum;
    logic [EXT_W-1:0]   pspan;
    logic [SAT_W-1:0]   sat_end;
    logic               emit_a;
    logic [TOTAL_W-1:0] cnt_a;
    logic [TOTAL_W-1:0] tot_a;
    logic [TOTAL_W-1:0] tot_b;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

    always_comb
    begin
        gap_zero = (item.gap == '0);
        flat     = SIZE_W'(item.block_size) * SIZE_W'(item.repeat_req);
        nsize    = gap_zero ? flat : SIZE_W'(item.block_size);
        nrep     = gap_zero ? REP_W'(1) : REP_W'(item.repeat_req);
        nspan    = SPAN_W'(item.block_size) + SPAN_W'(item.gap);
        ext_prod = EXT_W'(nspan) * EXT_W'(item.repeat_req);
        ext      = gap_zero ? EXT_W'(flat) : ext_prod;
        load_end = END_W'(item.base) + END_W'(ext);

        merge_ok = pv_reg && !pbig_reg && (pgap_reg == item.gap) && (pend_reg == item.base)
                   && ((psize_reg == nsize) || (pgap_reg == '0));

        ssum     = EXT_W'(psize_reg) + EXT_W'(nsize);
        size_sat = ssum[SIZE_W] ? SIZE_MAX : ssum[SIZE_W-1:0];
        zend     = EXT_W'(pbase_reg) + EXT_W'(size_sat);
        rsum     = (REP_W+1)'(prep_reg) + (REP_W+1)'(nrep);
        pspan    = EXT_W'(psize_reg) + EXT_W'(pgap_reg);
        sat_end  = SAT_W'(pbase_reg) + (SAT_W'(pspan) << REP_W) - SAT_W'(pspan);

        pv_next    = pv_reg;
        pbase_next = pbase_reg;
        psize_next = psize_reg;
        pgap_next  = pgap_reg;
        prep_next  = prep_reg;
        pend_next  = pend_reg;
        pbig_next  = pbig_reg;

        if (merge_ok)
        begin
            if (pgap_reg == '0)
            begin
                psize_next = size_sat;
                pend_next  = zend[BASE_W-1:0];
                pbig_next  = zend[BASE_W];
            end
            else if (rsum[REP_W])
            begin
                prep_next = REP_MAX;
                pend_next = sat_end[BASE_W-1:0];
                pbig_next = |sat_end[SAT_W-1:BASE_W];
            end
            else
            begin
                prep_next = rsum[REP_W-1:0];
                pend_next = load_end[BASE_W-1:0];
                pbig_next = |load_end[END_W-1:BASE_W];
            end
        end
        else
        begin
            pv_next    = 1'b1;
            pbase_next = item.base;
            psize_next = nsize;
            pgap_next  = item.gap;
            prep_next  = nrep;
            pend_next  = load_end[BASE_W-1:0];
            pbig_next  = |load_end[END_W-1:BASE_W];
        end

        emit_a = pv_reg && !merge_ok;
        tot_a  = sat_inc(cnt_reg);
        cnt_a  = emit_a ? tot_a : cnt_reg;
        tot_b  = sat_inc(cnt_a);

        if (item.last_item)
        begin
            pv_next  = 1'b0;
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_a;
        end

        emit.first  = fire && emit_a;
        emit.second = fire && item.last_item;

        res_a.base       = pbase_reg;
        res_a.size       = psize_reg;
        res_a.gap        = pgap_reg;
        res_a.repeat_cnt = prep_reg;
        res_a.last       = 1'b0;
        res_a.total      = tot_a;

        res_b.base       = pbase_next;
        res_b.size       = psize_next;
        res_b.gap        = pgap_next;
        res_b.repeat_cnt = prep_next;
        res_b.last       = 1'b1;
        res_b.total      = tot_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            pbase_reg <= '0;
            psize_reg <= '0;
            pgap_reg  <= '0;
            prep_reg  <= '0;
            pend_reg  <= '0;
            pbig_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            pv_reg    <= pv_next;
            pbase_reg <= pbase_next;
            psize_reg <= psize_next;
            pgap_reg  <= pgap_next;
            prep_reg  <= prep_next;
            pend_reg  <= pend_next;
            pbig_reg  <= pbig_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hw/rtl/sidc_out_fifo.sv
// Result queue that takes up to two results per cycle and hands out one per transfer.
`timescale 1ns / 1ps

module sidc_out_fifo
    import sidc_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  emit_t   push,
    input  result_t din_a,
    input  result_t din_b,
    output logic    room,
    output logic    dout_valid,
    input  logic    dout_stall,
    output result_t dout
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    result_t            dout_reg;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   slot_b;
    logic               pop;
    logic [CNT_W-1:0]   push_n;

    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign slot_b     = push.first ? wr_ptr_inc : wr_ptr_reg;
    assign pop        = dout_valid && !dout_stall;
    assign push_n     = CNT_W'(push.first) + CNT_W'(push.second);
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign dout_valid = (count_reg != '0);
    assign dout       = dout_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    // The head entry is kept in a register; a result written into the head slot
    // in the same cycle is taken straight from the write data.
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[wr_ptr_reg] <= din_a;
            if (push.second)
            begin
                mem[wr_ptr_inc] <= din_b;
            end
        end
        else if (push.second)
        begin
            mem[wr_ptr_reg] <= din_b;
        end

        if (push.first && (rd_ptr_next == wr_ptr_reg))
        begin
            dout_reg <= din_a;
        end
        else if (push.second && (rd_ptr_next == slot_b))
        begin
            dout_reg <= din_b;
        end
        else
        begin
            dout_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/strided_io_descriptor_coalescer.sv
// Top level of the strided descriptor coalescer: input register, merge unit and result queue.
//
// The input channel carries one strided descriptor per transfer (in_valid, in_stall) and
// the output channel carries one coalesced descriptor per transfer (out_valid, out_stall).
// Each input transfer yields zero, one or two output transfers; a descriptor with
// last_item set flushes the list, and its final result carries out_last and the count
// of descriptors emitted for the list in out_total.
// An input transfer is held in the input register; the merge unit writes its results into
// the queue, whose head is registered. Throughput is one descriptor per cycle while the
// queue has room, set by the single merge unit, deciding and updating the pending descriptor.
// Results enter a queue of OUT_DEPTH entries (a power of two, at least four); the merge
// unit runs only while two entries are free. When the receiver stalls, the queue fills,
// the input register holds its descriptor and in_stall rises until space returns.
// Reset empties the pending slot, the emitted count and the queue; the block accepts a
// descriptor in the first cycle after reset.
`timescale 1ns / 1ps

module strided_io_descriptor_coalescer
    import sidc_pkg::*;
#(
    parameter int OUT_DEPTH_P = OUT_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BASE_W-1:0]   base,
    input  logic [BSIZE_W-1:0]  block_size,
    input  logic [GAP_W-1:0]    gap,
    input  logic [REQ_W-1:0]    repeat_req,
    input  logic                last_item,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BASE_W-1:0]   out_base,
    output logic [SIZE_W-1:0]   out_size,
    output logic [GAP_W-1:0]    out_gap,
    output logic [REP_W-1:0]    out_repeat,
    output logic                out_last,
    output logic [TOTAL_W-1:0]  out_total
);

    item_t   item_reg;
    logic    item_vld_reg, item_vld_next;
    logic    room;
    logic    fire;
    logic    in_take;
    emit_t   emit;
    result_t res_a;
    result_t res_b;
    result_t dout;

    assign fire     = item_vld_reg && room;
    assign in_stall = item_vld_reg && !room;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            item_vld_next = 1'b1;
        end
        else if (fire)
        begin
            item_vld_next = 1'b0;
        end
        else
        begin
            item_vld_next = item_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.base       <= base;
            item_reg.block_size <= block_size;
            item_reg.gap        <= gap;
            item_reg.repeat_req <= repeat_req;
            item_reg.last_item  <= last_item;
        end
    end

    sidc_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .emit  (emit),
        .res_a (res_a),
        .res_b (res_b)
    );

    sidc_out_fifo #(
        .DEPTH (OUT_DEPTH_P)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .din_a      (res_a),
        .din_b      (res_b),
        .room       (room),
        .dout_valid (out_valid),
        .dout_stall (out_stall),
        .dout       (dout)
    );

    assign out_base   = dout.base;
    assign out_size   = dout.size;
    assign out_gap    = dout.gap;
    assign out_repeat = dout.repeat_cnt;
    assign out_last   = dout.last;
    assign out_total  = dout.total;

endmodule

### tb/sv/tb_strided_io_descriptor_coalescer.sv
// Self-checking testbench for the strided descriptor coalescer with directed and random lists.
`timescale 1ns / 1ps

module tb_strided_io_descriptor_coalescer;
    import sidc_pkg::*;

    localparam int HOLD_LEN = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [BASE_W-1:0]  base;
    logic [BSIZE_W-1:0] block_size;
    logic [GAP_W-1:0]   gap;
    logic [REQ_W-1:0]   repeat_req;
    logic               last_item;
    logic               out_valid;
    logic               out_stall;
    logic [BASE_W-1:0]  out_base;
    logic [SIZE_W-1:0]  out_size;
    logic [GAP_W-1:0]   out_gap;
    logic [REP_W-1:0]   out_repeat;
    logic               out_last;
    logic [TOTAL_W-1:0] out_total;

    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;

    // Mirror of the pending descriptor and the per-list emit counter.
    logic               pend_valid = 1'b0;
    logic [BASE_W-1:0]  pend_base = '0;
    logic [SIZE_W-1:0]  pend_size = '0;
    logic [GAP_W-1:0]   pend_gap = '0;
    logic [REP_W-1:0]   pend_rep = '0;
    logic [TOTAL_W-1:0] emit_cnt = '0;
    result_t            coalesced_q[$];

    strided_io_descriptor_coalescer u_top (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [127:0] pending_end();
        return 128'(pend_base) + (128'(pend_size) + 128'(pend_gap)) * 128'(pend_rep);
    endfunction

    task automatic emit_pending(input logic fin);
        result_t r;
        if (emit_cnt != '1)
            emit_cnt = emit_cnt + 1'b1;
        r.base       = pend_base;
        r.size       = pend_size;
        r.gap        = pend_gap;
        r.repeat_cnt = pend_rep;
        r.last       = fin;
        r.total      = emit_cnt;
        coalesced_q.push_back(r);
    endtask

    task automatic predict_coalesce(input item_t d);
        logic [SIZE_W-1:0] nsize;
        logic [REP_W-1:0]  nrep;
        logic [SIZE_W:0]   ssum;
        logic [REP_W:0]    rsum;
        nsize = SIZE_W'(d.block_size);
        nrep  = REP_W'(d.repeat_req);
        if (d.gap == '0)
        begin
            nsize = nsize * SIZE_W'(d.repeat_req);
            nrep  = 1;
        end
        if (pend_valid && pend_gap == d.gap && pending_end() == 128'(d.base) &&
            (pend_size == nsize || pend_gap == '0))
        begin
            if (pend_gap == '0)
            begin
                ssum = {1'b0, pend_size} + nsize;
                pend_size = ssum[SIZE_W] ? '1 : ssum[SIZE_W-1:0];
            end
            else
            begin
                rsum = {1'b0, pend_rep} + nrep;
                pend_rep = rsum[REP_W] ? '1 : rsum[REP_W-1:0];
            end
        end
        else
        begin
            if (pend_valid)
                emit_pending(1'b0);
            pend_valid = 1'b1;
            pend_base  = d.base;
            pend_size  = nsize;
            pend_gap   = d.gap;
            pend_rep   = nrep;
        end
        if (d.last_item)
        begin
            emit_pending(1'b1);
            pend_valid = 1'b0;
            emit_cnt   = '0;
        end
    endtask

    function automatic item_t mk_desc(input logic [BASE_W-1:0] b, input logic [BSIZE_W-1:0] s,
                                      input logic [GAP_W-1:0] g, input logic [REQ_W-1:0] r,
                                      input logic l);
        item_t d;
        d.base       = b;
        d.block_size = s;
        d.gap        = g;
        d.repeat_req = r;
        d.last_item  = l;
        return d;
    endfunction

    // Most descriptors continue the pending one so that merges happen often.
    function automatic item_t random_desc();
        item_t        d;
        logic [127:0] e;
        int           k;
        k = $urandom_range(99);
        d.base       = BASE_W'({$urandom, $urandom});
        d.block_size = ($urandom_range(3) == 0) ? $urandom : $urandom_range(64);
        d.gap        = ($urandom_range(2) == 0) ? '0 :
                       (($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 64));
        d.repeat_req = ($urandom_range(7) == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(8));
        d.last_item  = ($urandom_range(9) == 0);
        if (k < 60 && pend_valid)
        begin
            e = pending_end();
            if (e <= 128'({BASE_W{1'b1}}))
                d.base = e[BASE_W-1:0];
            d.gap = pend_gap;
            if (pend_gap != '0)
                d.block_size = pend_size[BSIZE_W-1:0];
            if (k < 5)
                d.base = d.base + 1'b1;
        end
        else if (k < 75)
        begin
            d.base = BASE_W'($urandom_range(4096));
        end
        return d;
    endfunction

    task automatic send_desc(input item_t d);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        base       <= d.base;
        block_size <= d.block_size;
        gap        <= d.gap;
        repeat_req <= d.repeat_req;
        last_item  <= d.last_item;
        do @(posedge clk); while (in_stall);
        predict_coalesce(d);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (coalesced_q.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (coalesced_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, expected none, got base %0h", $time, out_base);
            end
            else
            begin
                want = coalesced_q.pop_front();
                check_field("out_base", 64'(want.base), 64'(out_base));
                check_field("out_size", 64'(want.size), 64'(out_size));
                check_field("out_gap", 64'(want.gap), 64'(out_gap));
                check_field("out_repeat", 64'(want.repeat_cnt), 64'(out_repeat));
                check_field("out_last", 64'(want.last), 64'(out_last));
                check_field("out_total", 64'(want.total), 64'(out_total));
            end
        end
    end

    initial
    begin
        int seen;
        int left;
        seen = 0;
        left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                left = HOLD_LEN;
            end
            if (left > 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic test_basic_merges();
        send_desc(mk_desc(48'h0, 32'd16, 32'd0, 16'd4, 1'b0));
        send_desc(mk_desc(48'h40, 32'd64, 32'd0, 16'd1, 1'b1));
        send_desc(mk_desc(48'h1000, 32'd8, 32'd8, 16'd3, 1'b0));
        send_desc(mk_desc(48'h1030, 32'd8, 32'd8, 16'd2, 1'b0));
        send_desc(mk_desc(48'h1080, 32'd4, 32'd8, 16'd2, 1'b0));
        send_desc(mk_desc(48'h2000, 32'd4, 32'd8, 16'd2, 1'b1));
    endtask

    task automatic test_extremes();
        send_desc(mk_desc('1, '1, '1, '1, 1'b1));
        send_desc(mk_desc('0, '0, '0, '0, 1'b1));
        send_desc(mk_desc('0, '1, '0, '1, 1'b0));
        send_desc(mk_desc(48'h5, '1, '1, 16'd1, 1'b1));
    endtask

    task automatic test_zero_repeat();
        send_desc(mk_desc(48'h100, 32'h55, 32'd0, 16'd0, 1'b0));
        send_desc(mk_desc(48'h100, 32'd4, 32'h10, 16'd0, 1'b0));
        send_desc(mk_desc(48'h100, 32'd4, 32'h10, 16'd3, 1'b0));
        send_desc(mk_desc(48'h13c, 32'd4, 32'h10, 16'd0, 1'b1));
    endtask

    task automatic test_size_saturation();
        send_desc(mk_desc(48'h0, '1, 32'd0, '1, 1'b0));
        send_desc(mk_desc(48'hfffe_ffff_0001, '1, 32'd0, '1, 1'b0));
        send_desc(mk_desc('1, 32'd0, 32'd0, 16'd1, 1'b1));
    endtask

    task automatic test_end_overflow();
        send_desc(mk_desc(48'hffff_ffff_f000, 32'h100, 32'h100, 16'h20, 1'b0));
        send_desc(mk_desc(48'h0000_0000_3000, 32'h100, 32'h100, 16'h20, 1'b1));
    endtask

    task automatic run_random(input int n, input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (n) send_desc(random_desc());
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_seq++;
        repeat (40) send_desc(random_desc());
    endtask

    task automatic test_pause();
        run_random(30, 0, 20);
        drain();
        run_random(30, 0, 20);
    endtask

    initial
    begin
        item_t fin;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        base       = '0;
        block_size = '0;
        gap        = '0;
        repeat_req = '0;
        last_item  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_merges();
        test_extremes();
        test_zero_repeat();
        test_size_saturation();
        test_end_overflow();
        run_random(250, 0, 0);
        run_random(250, 47, 0);
        run_random(250, 0, 47);
        run_random(250, 31, 31);
        test_backpressure();
        test_pause();
        run_random(190, 0, 0);
        fin = random_desc();
        fin.last_item = 1'b1;
        send_desc(fin);
        drain();
        repeat (8) @(posedge clk);

        if (coalesced_q.size() != 0)
        begin
            errors++;
            $display("%0t: expected %0d more transfers, got none", $time, coalesced_q.size());
        end
        if (errors == 0)
            $display("tb_strided_io_descriptor_coalescer: done, clean");
        else
            $display("tb_strided_io_descriptor_coalescer: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_strided_io_descriptor_coalescer: done, errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sidc_pkg.sv
hw/rtl/sidc_merge.sv
hw/rtl/sidc_out_fifo.sv
hw/rtl/strided_io_descriptor_coalescer.sv
tb/sv/tb_strided_io_descriptor_coalescer.sv
